@@ hdl/itc_pkg.sv @@
// ----------------------------------------------------------------------------
// itc_pkg
// Shared constants, codes and item types of the interrupt and timer controller.
// ----------------------------------------------------------------------------
package itc_pkg;

  // Interrupt source layout
  localparam int IRQ_SOURCES     = 11;
  localparam int TIMER_COUNT     = 3;
  localparam int SOFT_IRQ_BIT    = 5;
  localparam int TIMER_FIRST_BIT = 6;
  localparam int SAMPLE_BIT      = 10;

  // Level-select bytes and the highest source bit that owns its own level
  localparam int LEVEL_BYTES   = 3;
  localparam int LEVEL_MAX_BIT = 7;

  // Width of the per-timer wrap flags on the result
  localparam int WRAP_W = 3;

  localparam logic [IRQ_SOURCES-1:0] SOFT_MASK   = IRQ_SOURCES'(32'd1 << SOFT_IRQ_BIT);
  localparam logic [IRQ_SOURCES-1:0] SAMPLE_MASK = IRQ_SOURCES'(32'd1 << SAMPLE_BIT);

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2
  } itc_action_e;

  typedef enum logic [3:0] {
    REG_FIRST_EN    = 4'd0,
    REG_FIRST_PEND  = 4'd1,
    REG_FIRST_CLR   = 4'd2,
    REG_SECOND_EN   = 4'd3,
    REG_SECOND_PEND = 4'd4,
    REG_SECOND_CLR  = 4'd5,
    REG_TIMER0      = 4'd6,
    REG_TIMER1      = 4'd7,
    REG_TIMER2      = 4'd8,
    REG_LEVEL0      = 4'd9,
    REG_LEVEL1      = 4'd10,
    REG_LEVEL2      = 4'd11
  } itc_reg_e;

  typedef struct packed {
    itc_action_e action;
    logic [3:0]  reg_select;
    logic [15:0] write_data;
    logic        access_size;
    logic        high_byte;
  } itc_item_t;

  typedef struct packed {
    logic [WRAP_W-1:0]      timers_wrapped;
    logic                   second_irq;
    logic [2:0]             first_level;
    logic [IRQ_SOURCES-1:0] first_pending;
    logic [15:0]            read_data;
  } itc_result_t;

endpackage

@@ hdl/itc_prio.sv @@
// ----------------------------------------------------------------------------
// itc_prio
// Level of the lowest pending source, taken from the three level-select bytes.
// ----------------------------------------------------------------------------
module itc_prio (
  input  logic [itc_pkg::IRQ_SOURCES-1:0] pend_i,
  input  logic [7:0]                      level_i [itc_pkg::LEVEL_BYTES],
  output logic [itc_pkg::LEVEL_BYTES-1:0] level_o
);
  import itc_pkg::*;

  logic [2:0] bit_idx;

  // Scan from the top so the lowest set bit wins; sources above bit 7 share its level
  always_comb begin
    level_o = '0;
    bit_idx = '0;
    for (int b = IRQ_SOURCES - 1; b >= 0; b--) begin
      if (pend_i[b]) begin
        bit_idx = (b > LEVEL_MAX_BIT) ? 3'(LEVEL_MAX_BIT) : 3'(b);
        for (int l = 0; l < LEVEL_BYTES; l++) begin
          level_o[l] = level_i[l][bit_idx];
        end
      end
    end
  end

endmodule

@@ hdl/itc_regs.sv @@
// ----------------------------------------------------------------------------
// itc_regs
// Control registers, prescaled timers and result logic for one item.
// ----------------------------------------------------------------------------
module itc_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  itc_pkg::itc_item_t   item_i,
  output itc_pkg::itc_result_t result_o
);
  import itc_pkg::*;

  logic [IRQ_SOURCES-1:0] first_enable_q, first_enable_d;
  logic [IRQ_SOURCES-1:0] first_pend_q, first_pend_d;
  logic [IRQ_SOURCES-1:0] second_enable_q, second_enable_d;
  logic [IRQ_SOURCES-1:0] second_pend_q, second_pend_d;
  logic [15:0]            timer_word_q [TIMER_COUNT];
  logic [15:0]            timer_word_d [TIMER_COUNT];
  logic [7:0]             step_q [TIMER_COUNT];
  logic [7:0]             step_d [TIMER_COUNT];
  logic [7:0]             left_q [TIMER_COUNT];
  logic [7:0]             left_d [TIMER_COUNT];
  logic [7:0]             level_q [LEVEL_BYTES];
  logic [7:0]             level_d [LEVEL_BYTES];

  logic [15:0]            lanes;
  logic [15:0]            data;
  logic [15:0]            rd_reg;
  logic [15:0]            rd;
  logic [15:0]            en_merge;
  logic [15:0]            tmr_merge;
  logic [7:0]             tmr_step;
  logic [WRAP_W-1:0]      wrapped;
  logic [IRQ_SOURCES-1:0] first_active;
  logic [2:0]             first_level;

  function automatic logic [15:0] merge_lanes(logic [15:0] old, logic [15:0] dat,
                                              logic [15:0] msk);
    return (old & ~msk) | (dat & msk);
  endfunction

  // Byte lanes touched by the access; the untouched lane carries zero
  always_comb begin
    if (item_i.access_size) begin
      lanes = 16'hFFFF;
      data  = item_i.write_data;
    end else if (item_i.high_byte) begin
      lanes = 16'hFF00;
      data  = {item_i.write_data[7:0], 8'h00};
    end else begin
      lanes = 16'h00FF;
      data  = {8'h00, item_i.write_data[7:0]};
    end
  end

  // Read select
  always_comb begin
    rd_reg = '0;
    unique case (item_i.reg_select) inside
      REG_FIRST_EN:    rd_reg = 16'(first_enable_q);
      REG_FIRST_PEND:  rd_reg = 16'(first_pend_q);
      REG_SECOND_EN:   rd_reg = 16'(second_enable_q);
      REG_SECOND_PEND: rd_reg = 16'(second_pend_q);
      REG_TIMER0, REG_TIMER1, REG_TIMER2: begin
        for (int t = 0; t < TIMER_COUNT; t++) begin
          if (item_i.reg_select == 4'(REG_TIMER0) + 4'(t)) rd_reg = timer_word_q[t];
        end
      end
      REG_LEVEL0, REG_LEVEL1, REG_LEVEL2: begin
        for (int l = 0; l < LEVEL_BYTES; l++) begin
          if (item_i.reg_select == 4'(REG_LEVEL0) + 4'(l)) rd_reg = 16'(level_q[l]);
        end
      end
      default: rd_reg = '0;
    endcase
    if (item_i.action != ACT_READ) begin
      rd = '0;
    end else if (item_i.access_size) begin
      rd = rd_reg;
    end else begin
      rd = {8'h00, item_i.high_byte ? rd_reg[15:8] : rd_reg[7:0]};
    end
  end

  // Next state for writes and sample ticks
  always_comb begin
    first_enable_d  = first_enable_q;
    first_pend_d    = first_pend_q;
    second_enable_d = second_enable_q;
    second_pend_d   = second_pend_q;
    timer_word_d    = timer_word_q;
    step_d          = step_q;
    left_d          = left_q;
    level_d         = level_q;
    wrapped         = '0;
    en_merge        = '0;
    tmr_merge       = '0;
    tmr_step        = '0;
    case (item_i.action)
      ACT_WRITE: begin
        unique case (item_i.reg_select) inside
          REG_FIRST_EN: begin
            en_merge       = merge_lanes(16'(first_enable_q), data, lanes);
            first_enable_d = en_merge[IRQ_SOURCES-1:0];
          end
          REG_FIRST_PEND: if (data[SOFT_IRQ_BIT]) first_pend_d = first_pend_q | SOFT_MASK;
          REG_FIRST_CLR:  first_pend_d = first_pend_q & ~data[IRQ_SOURCES-1:0];
          REG_SECOND_EN: begin
            en_merge        = merge_lanes(16'(second_enable_q), data, lanes);
            second_enable_d = en_merge[IRQ_SOURCES-1:0];
          end
          REG_SECOND_PEND: if (data[SOFT_IRQ_BIT]) second_pend_d = second_pend_q | SOFT_MASK;
          REG_SECOND_CLR:  second_pend_d = second_pend_q & ~data[IRQ_SOURCES-1:0];
          REG_TIMER0, REG_TIMER1, REG_TIMER2: begin
            for (int t = 0; t < TIMER_COUNT; t++) begin
              if (item_i.reg_select == 4'(REG_TIMER0) + 4'(t)) begin
                tmr_merge       = merge_lanes(timer_word_q[t], data, lanes);
                tmr_step        = 8'd1 << tmr_merge[10:8];
                timer_word_d[t] = tmr_merge;
                // Restart the prescaler only when the rate really changes
                if (tmr_step != step_q[t]) begin
                  step_d[t] = tmr_step;
                  left_d[t] = tmr_step;
                end
              end
            end
          end
          REG_LEVEL0, REG_LEVEL1, REG_LEVEL2: begin
            for (int l = 0; l < LEVEL_BYTES; l++) begin
              if (item_i.reg_select == 4'(REG_LEVEL0) + 4'(l) && lanes[0]) begin
                level_d[l] = data[7:0];
              end
            end
          end
          default: ;
        endcase
      end
      ACT_TICK: begin
        // Advance each prescaler; count the timer when it runs out
        for (int t = 0; t < TIMER_COUNT; t++) begin
          if (left_q[t] == 8'd1) begin
            left_d[t]            = step_q[t];
            timer_word_d[t][7:0] = timer_word_q[t][7:0] + 8'd1;
            if (timer_word_q[t][7:0] == 8'hFF) begin
              wrapped[t]    = 1'b1;
              first_pend_d  = first_pend_d | IRQ_SOURCES'(32'd1 << (TIMER_FIRST_BIT + t));
              second_pend_d = second_pend_d | IRQ_SOURCES'(32'd1 << (TIMER_FIRST_BIT + t));
            end
          end else begin
            left_d[t] = left_q[t] - 8'd1;
          end
        end
        first_pend_d  = first_pend_d | SAMPLE_MASK;
        second_pend_d = second_pend_d | SAMPLE_MASK;
      end
      default: ;
    endcase
  end

  // Interrupt view after the update
  assign first_active = first_enable_d & first_pend_d;

  itc_prio u_prio (
    .pend_i  (first_active),
    .level_i (level_d),
    .level_o (first_level)
  );

  always_comb begin
    result_o.read_data      = rd;
    result_o.first_pending  = first_active;
    result_o.first_level    = first_level;
    result_o.second_irq     = |(second_enable_d & second_pend_d);
    result_o.timers_wrapped = wrapped;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_enable_q  <= '0;
      first_pend_q    <= '0;
      second_enable_q <= '0;
      second_pend_q   <= '0;
      for (int t = 0; t < TIMER_COUNT; t++) begin
        timer_word_q[t] <= '0;
        step_q[t]       <= 8'd1;
        left_q[t]       <= 8'd1;
      end
      for (int l = 0; l < LEVEL_BYTES; l++) begin
        level_q[l] <= '0;
      end
    end else if (en_i) begin
      first_enable_q  <= first_enable_d;
      first_pend_q    <= first_pend_d;
      second_enable_q <= second_enable_d;
      second_pend_q   <= second_pend_d;
      timer_word_q    <= timer_word_d;
      step_q          <= step_d;
      left_q          <= left_d;
      level_q         <= level_d;
    end
  end

  a_tick_sets_sample : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.action == ACT_TICK |=>
      (first_pend_q & SAMPLE_MASK) == SAMPLE_MASK &&
      (second_pend_q & SAMPLE_MASK) == SAMPLE_MASK)
    else $error("sample tick did not set the sample-done bit");

  a_wrap_only_on_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.action != ACT_TICK |-> result_o.timers_wrapped == '0)
    else $error("timer wrap flagged on a register access");

  a_idle_holds_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(first_enable_q) && $stable(first_pend_q) &&
              $stable(second_enable_q) && $stable(second_pend_q))
    else $error("interrupt state changed without an item");

endmodule

@@ hdl/interrupt_and_timer_controller.sv @@
// ----------------------------------------------------------------------------
// interrupt_and_timer_controller
// Register access and sample-tick front end of the interrupt and timer block.
// ----------------------------------------------------------------------------
// Path: each item passes the input register and then the result register; an item waits in
// the input register while the result register is full and m_axis_tready is low.
// Throughput: one item per cycle unless m_axis_tready stalls the output; the register file
// updates in the cycle an item leaves the input register, so later items see its effects.
// Reset: rst_ni clears all masks, timers and level bytes; prescalers restart at one tick.
// Both pipeline registers come up empty.
module interrupt_and_timer_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_select[3:0], write_data[19:4], access_size[20], high_byte[21], zero[23:22]
  input  logic [23:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[15:0], first_pending[26:16], first_level[29:27], second_irq[30],
  // timers_wrapped[33:31], zero[39:34]
  output logic [39:0] m_axis_tdata
);
  import itc_pkg::*;

  itc_item_t   in_q, in_d;
  logic        in_valid_q, in_valid_d;
  itc_result_t out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        advance;
  logic        in_take;

  // Move an item on when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_d.action      = itc_action_e'(s_axis_tuser);
    in_d.reg_select  = s_axis_tdata[3:0];
    in_d.write_data  = s_axis_tdata[19:4];
    in_d.access_size = s_axis_tdata[20];
    in_d.high_byte   = s_axis_tdata[21];
    in_valid_d       = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d      = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  itc_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_q),
    .result_o (out_d)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_d;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.timers_wrapped, out_q.second_irq, out_q.first_level,
                          out_q.first_pending, out_q.read_data};

  a_stall_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled while the pipeline had room");

  a_advance_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("processed item did not reach the result register");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("waiting result changed or dropped");

endmodule
